### hdl/cqge_pkg.sv
package cqge_pkg;

    localparam int NUM_QUBITS = 12;
    localparam int FRAC_BITS  = 30;
    localparam int DIM        = 1 << NUM_QUBITS;
    localparam int IDX_W      = NUM_QUBITS;
    localparam int AMP_W      = 64;
    localparam int PADDR_W    = 6;

    typedef logic [1:0] kind_t;
    localparam kind_t KIND_WRITE = 2'd0;
    localparam kind_t KIND_READ  = 2'd1;
    localparam kind_t KIND_APPLY = 2'd2;

    typedef logic [1:0] mode_t;
    localparam mode_t MODE_MATRIX = 2'd0;
    localparam mode_t MODE_SWAP   = 2'd1;
    localparam mode_t MODE_PHASE  = 2'd2;

    localparam logic [2:0] REG_TARGET  = 3'd0;
    localparam logic [2:0] REG_CONTROL = 3'd1;
    localparam logic [2:0] REG_MODE    = 3'd2;
    localparam logic [2:0] REG_C00     = 3'd3;
    localparam logic [2:0] REG_C01     = 3'd4;
    localparam logic [2:0] REG_C10     = 3'd5;
    localparam logic [2:0] REG_C11     = 3'd6;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD,
        ST_SCAN,
        ST_LD0,
        ST_LD1,
        ST_MUL,
        ST_SUM,
        ST_RND,
        ST_WR0,
        ST_WR1,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic [63:0] c00;
        logic [63:0] c01;
        logic [63:0] c10;
        logic [63:0] c11;
        logic [IDX_W-1:0] tmask;
        logic [IDX_W-1:0] cmask;
        mode_t mode;
    } cfg_t;

endpackage

### hdl/cqge_if.sv
interface cqge_in_if (input logic clk);
    import cqge_pkg::*;
    logic valid;
    logic ready;
    kind_t kind;
    logic [11:0] index;
    logic signed [31:0] amp_re;
    logic signed [31:0] amp_im;
    modport source (output valid, kind, index, amp_re, amp_im, input ready);
    modport sink (input valid, kind, index, amp_re, amp_im, output ready);
endinterface

interface cqge_out_if (input logic clk);
    import cqge_pkg::*;
    logic valid;
    logic ready;
    logic signed [31:0] out_re;
    logic signed [31:0] out_im;
    kind_t done_kind;
    logic saturated;
    modport source (output valid, out_re, out_im, done_kind, saturated, input ready);
    modport sink (input valid, out_re, out_im, done_kind, saturated, output ready);
endinterface

### hdl/cqge_ram.sv
module cqge_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

### hdl/cqge_cfg.sv
module cqge_cfg (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [cqge_pkg::PADDR_W-1:0]  paddr,
    input  logic [63:0]                   pwdata,
    output logic [63:0]                   prdata,
    output logic                          pready,
    output cqge_pkg::cfg_t                cfg
);
    import cqge_pkg::*;

    cfg_t cfg_reg;
    logic [2:0] sel;

    assign sel    = paddr[PADDR_W-1:3];
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '{tmask: IDX_W'(1), default: '0};
        end
        else if (psel && penable && pwrite)
        begin
            unique case (sel)
                REG_TARGET:  cfg_reg.tmask <= pwdata[IDX_W-1:0];
                REG_CONTROL: cfg_reg.cmask <= pwdata[IDX_W-1:0];
                REG_MODE:    cfg_reg.mode  <= pwdata[1:0];
                REG_C00:     cfg_reg.c00   <= pwdata;
                REG_C01:     cfg_reg.c01   <= pwdata;
                REG_C10:     cfg_reg.c10   <= pwdata;
                REG_C11:     cfg_reg.c11   <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (sel)
            REG_TARGET:  prdata = 64'(cfg_reg.tmask);
            REG_CONTROL: prdata = 64'(cfg_reg.cmask);
            REG_MODE:    prdata = 64'(cfg_reg.mode);
            REG_C00:     prdata = cfg_reg.c00;
            REG_C01:     prdata = cfg_reg.c01;
            REG_C10:     prdata = cfg_reg.c10;
            REG_C11:     prdata = cfg_reg.c11;
            default:     prdata = '0;
        endcase
    end
endmodule

### hdl/cqge_dp.sv
module cqge_dp (
    input  logic         clk,
    input  logic         mul_en,
    input  logic         sum_en,
    input  logic         rnd_en,
    input  logic         sel_row,
    input  cqge_pkg::cfg_t cfg,
    input  logic [63:0]  v0,
    input  logic [63:0]  v1,
    output logic [63:0]  result,
    output logic         sat
);
    import cqge_pkg::*;

    logic [63:0] a, b;
    logic signed [31:0] ar, ai, br, bi, xr, xi, yr, yi;
    logic signed [63:0] p_reg [8];
    logic signed [65:0] sre_reg, sim_reg;
    logic signed [65:0] rre, rim;
    logic [31:0] ore, oim;
    logic sre_sat, sim_sat;

    assign a  = sel_row ? cfg.c10 : cfg.c00;
    assign b  = (cfg.mode == MODE_PHASE) ? 64'd0 : (sel_row ? cfg.c11 : cfg.c01);
    assign ar = a[63:32];
    assign ai = a[31:0];
    assign br = b[63:32];
    assign bi = b[31:0];
    assign xr = v0[63:32];
    assign xi = v0[31:0];
    assign yr = (cfg.mode == MODE_PHASE) ? 32'sd0 : v1[63:32];
    assign yi = (cfg.mode == MODE_PHASE) ? 32'sd0 : v1[31:0];

    always_ff @(posedge clk)
    begin
        if (mul_en)
        begin
            p_reg[0] <= ar * xr;
            p_reg[1] <= ai * xi;
            p_reg[2] <= br * yr;
            p_reg[3] <= bi * yi;
            p_reg[4] <= ar * xi;
            p_reg[5] <= ai * xr;
            p_reg[6] <= br * yi;
            p_reg[7] <= bi * yr;
        end
        if (sum_en)
        begin
            sre_reg <= 66'(p_reg[0]) - 66'(p_reg[1]) + 66'(p_reg[2]) - 66'(p_reg[3]);
            sim_reg <= 66'(p_reg[4]) + 66'(p_reg[5]) + 66'(p_reg[6]) + 66'(p_reg[7]);
        end
        if (rnd_en)
        begin
            result <= {ore, oim};
            sat    <= sre_sat | sim_sat;
        end
    end

    // round half up, then clamp to 32 bits
    assign rre = (sre_reg + (66'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
    assign rim = (sim_reg + (66'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;

    always_comb
    begin
        sre_sat = 1'b0;
        sim_sat = 1'b0;
        if (rre > 66'sd2147483647)
        begin
            ore = 32'h7fffffff;
            sre_sat = 1'b1;
        end
        else if (rre < -66'sd2147483648)
        begin
            ore = 32'h80000000;
            sre_sat = 1'b1;
        end
        else
        begin
            ore = rre[31:0];
        end
        if (rim > 66'sd2147483647)
        begin
            oim = 32'h7fffffff;
            sim_sat = 1'b1;
        end
        else if (rim < -66'sd2147483648)
        begin
            oim = 32'h80000000;
            sim_sat = 1'b1;
        end
        else
        begin
            oim = rim[31:0];
        end
    end
endmodule

### hdl/controlled_qubit_gate_engine.sv
// Controlled single-qubit gate engine on a 4096-entry complex state vector.
// Input channel (in_ch): kind, index, amp_re, amp_im. One result per item on
// out_ch: out_re, out_im (read data, else zero), done_kind, saturated.
// Configuration goes through the APB port; registers lie at 8*i, 64-bit data,
// and the user must write them only while the block is idle; the block itself
// does not enforce this. A write goes from idle straight to the result; a read
// passes ST_RD, where the registered RAM output is taken as the result.
// Apply: the scan steps through every index of the vector; per affected pair,
// matrix mode reads both entries, then multiplies, sums, rounds and writes
// each row; swap mode reads both and writes them back crossed; phase mode runs
// one row per controlled entry. One RAM port pair: one item in work at a time.
// The result sits in an output register; a stalled receiver holds it and
// the block takes no new item until it is transferred.
// Reset restores the configuration registers and the control state only; the
// amplitude RAM is not cleared and must be written before it is read.
module controlled_qubit_gate_engine (
    input  logic                          clk,
    input  logic                          rst_n,
    cqge_in_if.sink                       in_ch,
    cqge_out_if.source                    out_ch,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [cqge_pkg::PADDR_W-1:0]  paddr,
    input  logic [63:0]                   pwdata,
    output logic [63:0]                   prdata,
    output logic                          pready
);
    import cqge_pkg::*;

    cfg_t cfg;
    state_t state_reg, state_next;
    logic [IDX_W:0] i_reg, i_next;
    kind_t kind_reg;
    logic [IDX_W-1:0] idx_reg;
    logic [63:0] v0_reg, v1_reg, ores_reg;
    logic sat_reg, sat_next;
    logic sel_row_reg;

    logic [IDX_W-1:0] tm, t_lo, t_hi, both, cm, i_cur, a0, a1;
    logic match, mode_ok;
    logic we;
    logic [IDX_W-1:0] waddr, raddr;
    logic [63:0] wdata, rdata, dp_res;
    logic dp_sat;
    logic mul_en, sum_en, rnd_en;

    cqge_cfg u_cfg (
        .clk, .rst_n, .psel, .penable, .pwrite, .paddr, .pwdata,
        .prdata, .pready, .cfg
    );

    cqge_ram #(.WIDTH(AMP_W), .DEPTH(DIM)) u_ram (
        .clk, .we, .waddr, .wdata, .raddr, .rdata
    );

    cqge_dp u_dp (
        .clk, .mul_en, .sum_en, .rnd_en, .sel_row(sel_row_reg), .cfg,
        .v0(v0_reg), .v1(v1_reg), .result(dp_res), .sat(dp_sat)
    );

    assign tm    = cfg.tmask;
    assign t_lo  = tm & (~tm + IDX_W'(1));
    assign t_hi  = (tm & ~t_lo) & (~(tm & ~t_lo) + IDX_W'(1));
    assign i_cur = i_reg[IDX_W-1:0];

    always_comb
    begin
        both    = '0;
        cm      = cfg.cmask;
        mode_ok = 1'b0;
        a0      = i_cur;
        a1      = i_cur;
        unique case (cfg.mode)
            MODE_MATRIX:
            begin
                both    = t_lo;
                mode_ok = (t_lo != '0);
                a1      = i_cur | t_lo;
            end
            MODE_SWAP:
            begin
                both    = t_lo | t_hi;
                mode_ok = (t_lo != '0) && (t_hi != '0);
                a0      = i_cur | t_lo;
                a1      = i_cur | t_hi;
            end
            MODE_PHASE:
            begin
                mode_ok = 1'b1;
            end
            default: ;
        endcase
        cm    = cm & ~both;
        match = mode_ok && ((i_cur & cm) == cm) && ((i_cur & both) == '0);
    end

    always_comb
    begin
        state_next = state_reg;
        i_next     = i_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_ch.valid)
                begin
                    i_next = '0;
                    if (in_ch.kind == KIND_READ)
                        state_next = ST_RD;
                    else if (in_ch.kind == KIND_APPLY)
                        state_next = ST_SCAN;
                    else
                        state_next = ST_OUT;
                end
            end
            ST_RD:   state_next = ST_OUT;
            ST_SCAN:
            begin
                if (i_reg[IDX_W] || !mode_ok)
                    state_next = ST_OUT;
                else if (match)
                    state_next = ST_LD0;
                else
                    i_next = i_reg + 1'b1;
            end
            ST_LD0:  state_next = ST_LD1;
            ST_LD1:
            begin
                if (cfg.mode == MODE_SWAP)
                    state_next = ST_WR0;
                else
                    state_next = ST_MUL;
            end
            ST_MUL:  state_next = ST_SUM;
            ST_SUM:  state_next = ST_RND;
            ST_RND:
            begin
                if (!sel_row_reg)
                    state_next = ST_WR0;
                else
                    state_next = ST_WR1;
            end
            ST_WR0:
            begin
                if (cfg.mode == MODE_MATRIX)
                    state_next = ST_MUL;
                else if (cfg.mode == MODE_SWAP)
                    state_next = ST_WR1;
                else
                begin
                    state_next = ST_SCAN;
                    i_next     = i_reg + 1'b1;
                end
            end
            ST_WR1:
            begin
                state_next = ST_SCAN;
                i_next     = i_reg + 1'b1;
            end
            ST_OUT:
            begin
                if (out_ch.ready)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_ch.ready = (state_reg == ST_IDLE);
        mul_en      = (state_reg == ST_MUL);
        sum_en      = (state_reg == ST_SUM);
        rnd_en      = (state_reg == ST_RND);
        we          = 1'b0;
        waddr       = a0;
        wdata       = dp_res;
        raddr       = a0;
        sat_next    = sat_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                raddr    = in_ch.index;
                we       = in_ch.valid && (in_ch.kind == KIND_WRITE);
                waddr    = in_ch.index;
                wdata    = {in_ch.amp_re, in_ch.amp_im};
                sat_next = 1'b0;
            end
            ST_RD:   raddr = idx_reg;
            ST_LD0:  raddr = a1;
            ST_RND:  ;
            ST_WR0:
            begin
                we = 1'b1;
                if (cfg.mode == MODE_SWAP)
                    wdata = v1_reg;
                else
                    sat_next = sat_reg | dp_sat;
            end
            ST_WR1:
            begin
                we    = 1'b1;
                waddr = a1;
                if (cfg.mode == MODE_SWAP)
                    wdata = v0_reg;
                else
                    sat_next = sat_reg | dp_sat;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            i_reg       <= '0;
            sat_reg     <= 1'b0;
            sel_row_reg <= 1'b0;
            kind_reg    <= KIND_WRITE;
        end
        else
        begin
            state_reg <= state_next;
            i_reg     <= i_next;
            sat_reg   <= sat_next;
            if (state_reg == ST_IDLE && in_ch.valid)
            begin
                kind_reg <= in_ch.kind;
            end
            if (state_reg == ST_LD1)
                sel_row_reg <= 1'b0;
            else if (state_reg == ST_WR0)
                sel_row_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE)
        begin
            idx_reg  <= in_ch.index;
            ores_reg <= '0;
        end
        if (state_reg == ST_RD)
            ores_reg <= rdata;
        if (state_reg == ST_LD0)
            v0_reg <= rdata;
        if (state_reg == ST_LD1)
            v1_reg <= rdata;
    end

    assign out_ch.valid     = (state_reg == ST_OUT);
    assign out_ch.out_re    = ores_reg[63:32];
    assign out_ch.out_im    = ores_reg[31:0];
    assign out_ch.done_kind = kind_reg;
    assign out_ch.saturated = (kind_reg == KIND_APPLY) ? sat_reg : 1'b0;
endmodule

### hdl/cqge_checker.sv
module cqge_checker (
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic [1:0] in_kind,
    input logic out_valid,
    input logic out_ready,
    input logic [1:0] done_kind,
    input logic saturated,
    input logic [31:0] out_re
);
    import cqge_pkg::*;

    a_one_inflight: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready)
        else $error("input taken while result pending");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(done_kind))
        else $error("result dropped under stall");

    a_sat_apply: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && saturated |-> done_kind == KIND_APPLY)
        else $error("saturated on non-apply");

    a_re_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && done_kind != KIND_READ |-> out_re == '0)
        else $error("nonzero data on non-read");

    a_write_fast: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_kind == KIND_WRITE |=> out_valid)
        else $error("write result late");
endmodule

bind controlled_qubit_gate_engine cqge_checker u_chk (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_kind(in_ch.kind),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .done_kind(out_ch.done_kind), .saturated(out_ch.saturated),
    .out_re(out_ch.out_re)
);

### test/gate_checker.sv
module gate_checker
    import cqge_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    cqge_in_if                 in_ch,
    cqge_out_if                out_ch,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic               pready,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [63:0]        pwdata,
    output int                 errors,
    output int                 pending
);

    typedef struct {
        logic [31:0] re;
        logic [31:0] im;
        kind_t       kind;
        logic        sat;
    } gate_result_t;

    gate_result_t result_fifo[$];

    logic [IDX_W-1:0] tmask;
    logic [IDX_W-1:0] cmask;
    mode_t            mode;
    logic [63:0]      c00, c01, c10, c11;
    logic [63:0]      amps [DIM];

    task automatic report(input string what, input logic [31:0] want, input logic [31:0] got);
        $display("%0t: %s expected %h got %h", $time, what, want, got);
        errors++;
    endtask

    function automatic logic [31:0] round_clip(input logic signed [65:0] acc, inout logic sat);
        logic signed [65:0] r;
        r = (acc + (66'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
        if (r > 66'sd2147483647) begin
            r = 66'sd2147483647;
            sat = 1'b1;
        end
        else if (r < -66'sd2147483648) begin
            r = -66'sd2147483648;
            sat = 1'b1;
        end
        return r[31:0];
    endfunction

    // a*x + b*y on packed complex Q2.30, real part in the high half
    function automatic logic [63:0] cmul_acc(input logic [63:0] a, input logic [63:0] x,
                                             input logic [63:0] b, input logic [63:0] y,
                                             inout logic sat);
        logic signed [31:0] ar, ai, br, bi, xr, xi, yr, yi;
        logic signed [65:0] re_acc, im_acc;
        ar = a[63:32]; ai = a[31:0]; br = b[63:32]; bi = b[31:0];
        xr = x[63:32]; xi = x[31:0]; yr = y[63:32]; yi = y[31:0];
        re_acc = 66'(longint'(ar) * xr) - 66'(longint'(ai) * xi)
               + 66'(longint'(br) * yr) - 66'(longint'(bi) * yi);
        im_acc = 66'(longint'(ar) * xi) + 66'(longint'(ai) * xr)
               + 66'(longint'(br) * yi) + 66'(longint'(bi) * yr);
        return {round_clip(re_acc, sat), round_clip(im_acc, sat)};
    endfunction

    function automatic logic [IDX_W-1:0] low_one(input logic [IDX_W-1:0] m);
        return m & (~m + 1'b1);
    endfunction

    function automatic logic apply_gate();
        logic             sat;
        logic [IDX_W-1:0] lo, hi, both, c;
        logic [63:0]      v0, v1;
        sat = 1'b0;
        if (mode == MODE_MATRIX) begin
            lo = low_one(tmask);
            c = cmask & ~lo;
            if (lo != 0) begin
                for (int i = 0; i < DIM; i++) begin
                    if ((IDX_W'(i) & c) == c && (IDX_W'(i) & lo) == 0) begin
                        v0 = amps[i];
                        v1 = amps[i | lo];
                        amps[i] = cmul_acc(c00, v0, c01, v1, sat);
                        amps[i | lo] = cmul_acc(c10, v0, c11, v1, sat);
                    end
                end
            end
        end
        else if (mode == MODE_SWAP) begin
            lo = low_one(tmask);
            hi = low_one(tmask & ~lo);
            both = lo | hi;
            c = cmask & ~both;
            if (lo != 0 && hi != 0) begin
                for (int i = 0; i < DIM; i++) begin
                    if ((IDX_W'(i) & c) == c && (IDX_W'(i) & both) == 0) begin
                        v0 = amps[i | lo];
                        amps[i | lo] = amps[i | hi];
                        amps[i | hi] = v0;
                    end
                end
            end
        end
        else if (mode == MODE_PHASE) begin
            for (int i = 0; i < DIM; i++) begin
                if ((IDX_W'(i) & cmask) == cmask)
                    amps[i] = cmul_acc(c00, amps[i], 64'd0, 64'd0, sat);
            end
        end
        return sat;
    endfunction

    always @(posedge clk or negedge rst_n) begin
        gate_result_t want;
        gate_result_t got;
        if (!rst_n) begin
            tmask = 1;
            cmask = 0;
            mode = MODE_MATRIX;
            c00 = 0; c01 = 0; c10 = 0; c11 = 0;
            result_fifo.delete();
        end
        else begin
            if (psel && penable && pwrite && pready) begin
                case (3'(paddr >> 3))
                    REG_TARGET:  tmask = pwdata[IDX_W-1:0];
                    REG_CONTROL: cmask = pwdata[IDX_W-1:0];
                    REG_MODE:    mode = pwdata[1:0];
                    REG_C00:     c00 = pwdata;
                    REG_C01:     c01 = pwdata;
                    REG_C10:     c10 = pwdata;
                    REG_C11:     c11 = pwdata;
                    default: ;
                endcase
            end
            if (in_ch.valid && in_ch.ready) begin
                want = '{re: 0, im: 0, kind: in_ch.kind, sat: 0};
                if (in_ch.kind == KIND_WRITE)
                    amps[in_ch.index] = {in_ch.amp_re, in_ch.amp_im};
                else if (in_ch.kind == KIND_READ)
                    {want.re, want.im} = amps[in_ch.index];
                else if (in_ch.kind == KIND_APPLY)
                    want.sat = apply_gate();
                result_fifo.push_back(want);
            end
            if (out_ch.valid && out_ch.ready) begin
                got = '{re: out_ch.out_re, im: out_ch.out_im,
                        kind: out_ch.done_kind, sat: out_ch.saturated};
                if (result_fifo.size() == 0) begin
                    $display("%0t: result transfer with nothing outstanding", $time);
                    errors++;
                end
                else begin
                    want = result_fifo.pop_front();
                    if (got.kind != want.kind)
                        report("done_kind", 32'(want.kind), 32'(got.kind));
                    if (got.re != want.re) report("out_re", want.re, got.re);
                    if (got.im != want.im) report("out_im", want.im, got.im);
                    if (got.sat != want.sat)
                        report("saturated", 32'(want.sat), 32'(got.sat));
                end
            end
        end
        pending = result_fifo.size();
    end

endmodule

### test/testbench.sv
module testbench;
    import cqge_pkg::*;

    localparam kind_t KIND_UNUSED = 2'd3;
    localparam mode_t MODE_UNUSED = 2'd3;
    localparam logic [63:0] COEF_MAX = 64'h7FFFFFFF_7FFFFFFF;
    localparam logic [63:0] COEF_MIN = 64'h80000000_80000000;
    localparam logic [63:0] COEF_HALF_RT = 64'h2D413CCD_00000000;
    localparam logic [63:0] COEF_NEG_HALF_RT = 64'hD2BEC333_00000000;
    localparam logic [63:0] COEF_ONE = 64'h40000000_00000000;
    // every gate keeps these bits among its controls, so it only reaches this region
    localparam logic [11:0] REGION = 12'hE00;
    localparam int REGION_SIZE = 512;

    logic clk;
    logic rst_n;
    logic psel, penable, pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [63:0] pwdata, prdata;
    logic pready;
    int errors, pending;
    int items_sent, applies_sent;
    logic choke, start_choke;

    cqge_in_if  in_ch (clk);
    cqge_out_if out_ch (clk);

    controlled_qubit_gate_engine DUT (
        .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    gate_checker u_checker (
        .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
        .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
        .paddr(paddr), .pwdata(pwdata), .errors(errors), .pending(pending)
    );

    initial begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    initial begin
        #60000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [11:0] region_index();
        return REGION | 12'($urandom_range(0, REGION_SIZE - 1));
    endfunction

    // receiver: random ready runs and stalls, dropped entirely while choked
    initial begin
        int run;
        logic level;
        out_ch.ready = 0;
        level = 1;
        run = 0;
        forever begin
            @(posedge clk);
            if (run == 0) begin
                level = ~level;
                run = level ? $urandom_range(1, 30) : pick_gap();
            end
            else
                run--;
            out_ch.ready <= (choke || run == 0 && !level) ? 1'b0 : level;
        end
    end

    initial begin
        choke = 0;
        wait (start_choke);
        @(posedge clk);
        choke <= 1;
        repeat (400) @(posedge clk);
        choke <= 0;
    end

    task automatic send_item(input kind_t k, input logic [11:0] idx,
                             input logic [31:0] re, input logic [31:0] im);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            in_ch.valid <= 0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid <= 1;
        in_ch.kind <= k;
        in_ch.index <= idx;
        in_ch.amp_re <= re;
        in_ch.amp_im <= im;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
        items_sent++;
        if (k == KIND_APPLY) applies_sent++;
    endtask

    task automatic drain();
        in_ch.valid <= 0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic reg_write(input logic [2:0] r, input logic [63:0] value);
        psel <= 1;
        penable <= 0;
        pwrite <= 1;
        paddr <= PADDR_W'(r) << 3;
        pwdata <= value;
        @(posedge clk);
        penable <= 1;
        @(posedge clk);
        psel <= 0;
        penable <= 0;
        pwrite <= 0;
    endtask

    task automatic set_gate(input logic [11:0] t, input logic [11:0] c, input mode_t m,
                            input logic [63:0] a, input logic [63:0] b,
                            input logic [63:0] d, input logic [63:0] e);
        drain();
        reg_write(REG_TARGET, 64'(t));
        reg_write(REG_CONTROL, 64'(c));
        reg_write(REG_MODE, 64'(m));
        reg_write(REG_C00, a);
        reg_write(REG_C01, b);
        reg_write(REG_C10, d);
        reg_write(REG_C11, e);
    endtask

    function automatic logic [31:0] rand_part();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return 32'h7FFFFFFF;
        if (r == 1) return 32'h80000000;
        if (r < 5) return $urandom_range(0, 32'h7FFFFFFF) >> $urandom_range(0, 8);
        return $urandom;
    endfunction

    function automatic logic [63:0] rand_coef();
        logic [31:0] re, im;
        if ($urandom_range(0, 7) == 0) return $urandom_range(0, 1) ? COEF_MAX : COEF_MIN;
        re = $signed($urandom) >>> $urandom_range(1, 3);
        im = $signed($urandom) >>> $urandom_range(1, 3);
        return {re, im};
    endfunction

    // writes and reads stay inside the region that the gates reach
    task automatic random_items(input int n, input int apply_pct);
        int r;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(0, 99);
            if (r < apply_pct)
                send_item(KIND_APPLY, 12'($urandom), $urandom, $urandom);
            else if (r < 48)
                send_item(KIND_WRITE, region_index(), rand_part(), rand_part());
            else if (r < 95)
                send_item(KIND_READ, region_index(), $urandom, $urandom);
            else
                send_item(KIND_UNUSED, 12'($urandom), $urandom, $urandom);
        end
    endtask

    initial begin
        logic [11:0] t, c;
        mode_t m;
        int r;
        rst_n = 0;
        psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
        in_ch.valid = 0; in_ch.kind = KIND_WRITE; in_ch.index = 0;
        in_ch.amp_re = 0; in_ch.amp_im = 0;
        items_sent = 0; applies_sent = 0; start_choke = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // fill the region so every apply reads written entries
        for (int i = 0; i < REGION_SIZE; i++) begin
            if (i == 0)
                send_item(KIND_WRITE, REGION, 32'h7FFFFFFF, 32'h7FFFFFFF);
            else if (i == REGION_SIZE - 1)
                send_item(KIND_WRITE, 12'hFFF, 32'h80000000, 32'h80000000);
            else if (i == 1)
                send_item(KIND_WRITE, REGION | 12'h001, 32'h80000000, 32'h7FFFFFFF);
            else
                send_item(KIND_WRITE, REGION | 12'(i), rand_part(), rand_part());
        end
        send_item(KIND_READ, REGION, 0, 0);
        send_item(KIND_READ, 12'hFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
        send_item(KIND_UNUSED, 12'hFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);

        // saturating matrix on a small controlled slice
        set_gate(12'h001, 12'hFFE, MODE_MATRIX, COEF_MAX, COEF_MAX, COEF_MIN, COEF_MIN);
        send_item(KIND_APPLY, 0, 0, 0);
        send_item(KIND_READ, 12'hFFE, 0, 0);
        send_item(KIND_READ, 12'hFFF, 0, 0);
        // Hadamard on bit 8 over the whole region
        set_gate(12'h100, REGION, MODE_MATRIX, COEF_HALF_RT, COEF_HALF_RT,
                 COEF_HALF_RT, COEF_NEG_HALF_RT);
        send_item(KIND_APPLY, 0, 0, 0);
        send_item(KIND_READ, 12'hF00, 0, 0);
        // several targets: lowest used; control overlapping target
        set_gate(12'h006, 12'hFF2, MODE_MATRIX, COEF_ONE, rand_coef(), rand_coef(), COEF_ONE);
        send_item(KIND_APPLY, 0, 0, 0);
        send_item(KIND_READ, 12'hFF0, 0, 0);
        // no target bit at all
        set_gate(12'h000, 12'hF00, MODE_MATRIX, COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX);
        send_item(KIND_APPLY, 0, 0, 0);
        // swaps: two bits, three bits, one bit only
        set_gate(12'h0C0, 12'hF00, MODE_SWAP, 64'd0, 64'd0, 64'd0, 64'd0);
        send_item(KIND_APPLY, 0, 0, 0);
        send_item(KIND_READ, 12'hF40, 0, 0);
        set_gate(12'h111, 12'hEEE, MODE_SWAP, 64'd0, 64'd0, 64'd0, 64'd0);
        send_item(KIND_APPLY, 0, 0, 0);
        set_gate(12'h010, 12'hF00, MODE_SWAP, 64'd0, 64'd0, 64'd0, 64'd0);
        send_item(KIND_APPLY, 0, 0, 0);
        // phase by -2-2i on all-ones controls saturates
        set_gate(12'h001, 12'hFFF, MODE_PHASE, COEF_MIN, 64'd0, 64'd0, 64'd0);
        send_item(KIND_APPLY, 0, 0, 0);
        send_item(KIND_READ, 12'hFFF, 0, 0);
        set_gate(12'hFFF, 12'hFFF, MODE_UNUSED, COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX);
        send_item(KIND_APPLY, 0, 0, 0);

        for (int p = 0; p < 16; p++) begin
            r = $urandom_range(0, 9);
            m = r < 6 ? MODE_MATRIX : r < 8 ? MODE_SWAP : r < 9 ? MODE_PHASE : MODE_UNUSED;
            t = 12'($urandom) & 12'h1FF;
            if ($urandom_range(0, 1)) t = 12'(1) << $urandom_range(0, 8);
            c = 12'($urandom) | 12'($urandom) | 12'($urandom) | REGION;
            if (p == 7) c = REGION;
            set_gate(t, c, m, rand_coef(), rand_coef(), rand_coef(), rand_coef());
            if (p == 3) start_choke <= 1;
            random_items(p == 7 ? 20 : 66, p == 7 ? 5 : 6);
        end

        drain();
        $display("covered %0d items, %0d gate applications, over matrix, swap, phase and",
                 items_sent, applies_sent);
        $display("unused modes with random masks, coefficients and handshake stalls");
        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

### files.f
hdl/cqge_pkg.sv
hdl/cqge_if.sv
hdl/cqge_ram.sv
hdl/cqge_cfg.sv
hdl/cqge_dp.sv
hdl/controlled_qubit_gate_engine.sv
hdl/cqge_checker.sv
test/gate_checker.sv
test/testbench.sv
